/* src/qsu_pkg.sv */
// Shared constants for the quoted string unescaper: phase and status codes,
// character codes and the escape mapping function. No dependencies.
package qsu_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] status_t;
    typedef logic [1:0] phase_t;

    // Parser phase codes
    localparam phase_t PH_IDLE = 2'd0;
    localparam phase_t PH_BODY = 2'd1;
    localparam phase_t PH_ESC  = 2'd2;

    // Result status codes
    localparam status_t ST_BYTE = 2'd0;
    localparam status_t ST_DONE = 2'd1;
    localparam status_t ST_FAIL = 2'd2;

    // Input kind codes
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOI  = 1'b1;

    localparam byte_t CH_QUOTE  = 8'h22;
    localparam byte_t CH_BSLASH = 8'h5C;
    localparam byte_t CH_T      = 8'h74;
    localparam byte_t CH_R      = 8'h72;
    localparam byte_t CH_F      = 8'h66;
    localparam byte_t CH_N      = 8'h6E;
    localparam byte_t CH_B      = 8'h62;

    typedef struct packed {
        logic  known;
        byte_t value;
    } esc_map_t;

    function automatic esc_map_t map_escape(input byte_t b);
        esc_map_t m;
        m.known = 1'b1;
        case (b)
            CH_BSLASH: m.value = 8'h5C;
            CH_QUOTE:  m.value = 8'h22;
            CH_T:      m.value = 8'h09;
            CH_R:      m.value = 8'h0D;
            CH_F:      m.value = 8'h0C;
            CH_N:      m.value = 8'h0A;
            CH_B:      m.value = 8'h08;
            default:
            begin
                m.known = 1'b0;
                m.value = b;
            end
        endcase
        return m;
    endfunction

endpackage

/* src/quoted_string_unescaper.sv */
// Quoted string unescaper top level: decodes one double-quoted string per
// stream into content bytes plus a done/fail status. Depends on qsu_pkg.
//
// One input transfer per cycle is taken while the output is not stalled,
// decoded in a single pass and written to the result register, so a stream
// with no unknown escapes runs at one byte per clock. An unknown escape
// produces two results (the backslash, then the escape byte); the second sits
// in a pending register and the input stalls until it has been drained.
// The opening quote and a backslash inside the string produce no result. On
// failure the bytes already delivered are not recalled; the consumer drops
// them. After success or failure the block waits for a new opening quote.
module quoted_string_unescaper (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            kind,
    input  qsu_pkg::byte_t  in_byte,
    output logic            out_valid,
    input  logic            out_stall,
    output qsu_pkg::byte_t  out_byte,
    output qsu_pkg::status_t status,
    output logic            last
);
    import qsu_pkg::*;

    phase_t  phase_reg, phase_next;
    logic    out_valid_reg;
    byte_t   out_byte_reg;
    status_t status_reg;
    logic    last_reg;
    logic    pend_valid_reg;
    byte_t   pend_byte_reg;

    logic     out_take, out_free, in_take, eoi;
    logic     r0_en, r1_en;
    byte_t    r0_byte;
    status_t  r0_status;
    logic     r0_last;
    esc_map_t esc;

    assign out_take = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || out_take;
    assign in_stall = pend_valid_reg || !out_free;
    assign in_take  = in_valid && !in_stall;
    assign eoi      = (kind == KIND_EOI);
    assign esc      = map_escape(in_byte);

    always_comb
    begin
        phase_next = phase_reg;
        r0_en      = 1'b0;
        r1_en      = 1'b0;
        r0_byte    = '0;
        r0_status  = ST_BYTE;
        r0_last    = 1'b1;
        case (phase_reg)
            PH_BODY:
            begin
                r0_en = 1'b1;
                if (eoi)
                begin
                    phase_next = PH_IDLE;
                    r0_status  = ST_FAIL;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    phase_next = PH_IDLE;
                    r0_status  = ST_DONE;
                end
                else if (in_byte == CH_BSLASH)
                begin
                    phase_next = PH_ESC;
                    r0_en      = 1'b0;
                end
                else
                begin
                    r0_byte = in_byte;
                end
            end
            PH_ESC:
            begin
                r0_en = 1'b1;
                if (eoi)
                begin
                    phase_next = PH_IDLE;
                    r0_status  = ST_FAIL;
                end
                else
                begin
                    phase_next = PH_BODY;
                    if (esc.known)
                    begin
                        r0_byte = esc.value;
                    end
                    else
                    begin
                        // unknown escape: backslash now, escape byte next
                        r0_byte = CH_BSLASH;
                        r0_last = 1'b0;
                        r1_en   = 1'b1;
                    end
                end
            end
            default:
            begin
                // idle, and the unused phase code
                if (!eoi && in_byte == CH_QUOTE)
                begin
                    phase_next = PH_BODY;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    r0_en      = 1'b1;
                    r0_status  = ST_FAIL;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                phase_reg <= phase_next;
            end
            if (in_take && r0_en)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= r1_en;
            end
            else if (pend_valid_reg && out_free)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take && r0_en)
        begin
            out_byte_reg  <= r0_byte;
            status_reg    <= r0_status;
            last_reg      <= r0_last;
            pend_byte_reg <= in_byte;
        end
        else if (pend_valid_reg && out_free)
        begin
            out_byte_reg <= pend_byte_reg;
            status_reg   <= ST_BYTE;
            last_reg     <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule
